@@ sv/sha256_pkg.sv @@
// Package: SHA-256 constants, types and round functions.
`default_nettype none
package sha256_pkg;

    localparam logic [31:0] K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_ROUND, S_FOLD, S_OUT
    } t_state;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       message_end;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out_beat;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ sv/sha256_if.sv @@
// Interfaces: valid/ready channels for input bytes and digest words.
`default_nettype none
interface sha256_in_if;
    logic                  valid;
    logic                  ready;
    sha256_pkg::t_in_beat  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
    logic                  valid;
    logic                  ready;
    sha256_pkg::t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ sv/sha256_round.sv @@
// Round unit: one SHA-256 compression round with schedule extension.
`default_nettype none
module sha256_round (
    input  wire logic [31:0] i_v [8],
    input  wire logic [31:0] i_w [16],
    input  wire logic [5:0]  i_t,
    output logic      [31:0] o_v [8],
    output logic      [31:0] o_wnew
);
    logic [31:0] s0, s1, wt, t1, t2;
    always_comb begin
        s0 = sha256_pkg::ror(i_w[1], 7) ^ sha256_pkg::ror(i_w[1], 18) ^ (i_w[1] >> 3);
        s1 = sha256_pkg::ror(i_w[14], 17) ^ sha256_pkg::ror(i_w[14], 19) ^ (i_w[14] >> 10);
        // window holds w[t-16..t-1] at [0..15] in extension rounds
        o_wnew = (i_t < 6'd16) ? i_w[i_t[3:0]] : (i_w[0] + s0 + i_w[9] + s1);
        wt = o_wnew;
        t1 = i_v[7] + (sha256_pkg::ror(i_v[4], 6) ^ sha256_pkg::ror(i_v[4], 11)
             ^ sha256_pkg::ror(i_v[4], 25)) + ((i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]))
             + sha256_pkg::K[i_t] + wt;
        t2 = (sha256_pkg::ror(i_v[0], 2) ^ sha256_pkg::ror(i_v[0], 13)
             ^ sha256_pkg::ror(i_v[0], 22))
             + ((i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]));
        o_v[7] = i_v[6]; o_v[6] = i_v[5]; o_v[5] = i_v[4]; o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2]; o_v[2] = i_v[1]; o_v[1] = i_v[0]; o_v[0] = t1 + t2;
    end
endmodule
`default_nettype wire

@@ sv/sha256_byte_stream_hasher.sv @@
// Top level: SHA-256 hasher over a byte stream with an iterative round unit.
// Bytes enter one per beat on in_ch and are packed big-endian into a 16-word block.
// A data beat that does not fill the block leaves the hasher idle. A beat filling the
// 64th byte runs one compression, the rounds through the shared round unit and
// then the fold, with in_ch not ready until it is done. A beat with
// message_end pads the block one byte per cycle, the 0x80 marker first, up to
// byte 55 when the length field still fits and up to byte 63 when it does not.
// It then runs one or two compressions, with a second pad pass
// up to byte 55 between two of them, and presents eight digest beats on out_ch,
// word 0 first, each held until taken. The hasher then returns to the initial
// hash value; an end beat with no byte closes the message, so alone it hashes the empty message.
`default_nettype none
module sha256_byte_stream_hasher (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    sha256_in_if.sink       in_ch,
    sha256_out_if.source    out_ch
);
    sha256_pkg::t_state r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [60:0] r_len;       // byte count; bit length is this shifted by 3
    logic [5:0]  r_t;
    logic        r_end;       // closing the message
    logic        r_lenblk;    // current block carries the length field
    logic        r_padded;    // 0x80 marker already placed
    logic [2:0]  r_word;

    logic [31:0] rv_next [8];
    logic [31:0] w_new;

    sha256_round u_round (.i_v(r_v), .i_w(r_w), .i_t(r_t), .o_v(rv_next), .o_wnew(w_new));

    logic take;
    assign in_ch.ready = (r_state == sha256_pkg::S_IDLE);
    assign take = in_ch.valid && in_ch.ready;
    assign out_ch.valid = (r_state == sha256_pkg::S_OUT);
    assign out_ch.payload.digest_word = r_h[r_word];
    assign out_ch.payload.word_number = r_word;
    assign out_ch.payload.last_word   = (r_word == 3'd7);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::S_IDLE: begin
                if (take) begin
                    if (in_ch.payload.byte_present && r_fill == 6'd63) n_state = sha256_pkg::S_ROUND;
                    else if (in_ch.payload.message_end) n_state = sha256_pkg::S_PAD;
                end
            end
            sha256_pkg::S_PAD: begin
                // stop at the length field, or at the block end when it cannot fit
                if (r_fill == 6'd63 || r_fill == 6'd55) n_state = sha256_pkg::S_ROUND;
            end
            sha256_pkg::S_ROUND: if (r_t == 6'd63) n_state = sha256_pkg::S_FOLD;
            sha256_pkg::S_FOLD: begin
                if (!r_end) n_state = sha256_pkg::S_IDLE;
                else if (r_lenblk) n_state = sha256_pkg::S_OUT;
                else n_state = sha256_pkg::S_PAD;
            end
            sha256_pkg::S_OUT: if (out_ch.ready && r_word == 3'd7) n_state = sha256_pkg::S_IDLE;
            default: n_state = sha256_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sha256_pkg::S_IDLE;
        else r_state <= n_state;
    end

    // byte write into the word window
    function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] pos,
                                        input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[8*(3-pos) +: 8] = b;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::H_INIT[i];
            r_fill <= '0; r_len <= '0; r_t <= '0; r_end <= 1'b0;
            r_lenblk <= 1'b0; r_padded <= 1'b0; r_word <= '0;
        end else begin
            unique case (r_state)
                sha256_pkg::S_IDLE: begin
                    r_t <= '0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    if (take) begin
                        r_end <= in_ch.payload.message_end;
                        r_padded <= 1'b0;
                        if (in_ch.payload.byte_present) begin
                            r_w[r_fill[5:2]] <= put(r_w[r_fill[5:2]], r_fill[1:0],
                                                    in_ch.payload.message_byte);
                            r_fill <= r_fill + 6'd1;
                            r_len <= r_len + 61'd1;
                        end
                    end
                end
                sha256_pkg::S_PAD: begin
                    // the first pad byte is the 0x80 marker, zeros follow
                    r_w[r_fill[5:2]] <= put(r_w[r_fill[5:2]], r_fill[1:0],
                                            r_padded ? 8'h00 : sha256_pkg::PAD_BYTE);
                    r_padded <= 1'b1;
                    if (r_fill == 6'd55) begin
                        r_w[14] <= {r_len[60:29]};
                        r_w[15] <= {r_len[28:0], 3'b000};
                        r_lenblk <= 1'b1;
                        r_fill <= '0;
                    end else begin
                        r_fill <= r_fill + 6'd1;
                    end
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_t <= '0;
                end
                sha256_pkg::S_ROUND: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= rv_next[i];
                    if (r_t >= 6'd16) begin
                        // shift window once the first sixteen words are used
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= w_new;
                    end
                    r_t <= r_t + 6'd1;
                end
                sha256_pkg::S_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_fill <= '0;
                    r_word <= '0;
                end
                sha256_pkg::S_OUT: begin
                    if (out_ch.ready) begin
                        r_word <= r_word + 3'd1;
                        if (r_word == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::H_INIT[i];
                            r_len <= '0; r_fill <= '0; r_lenblk <= 1'b0; r_end <= 1'b0;
                            r_padded <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::S_ROUND) |-> !in_ch.ready)
        else $error("ready during rounds");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (r_state == sha256_pkg::S_OUT))
        else $error("digest valid outside output phase");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.payload)))
        else $error("digest beat changed while waiting");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("input ready while digest pending");
endmodule
`default_nettype wire

@@ tb/sv/sha256_byte_stream_hasher_tb.sv @@
// Testbench: checks streamed SHA-256 digests against an in-bench hash predictor.
`default_nettype none
module sha256_byte_stream_hasher_tb;

    logic i_clk;
    logic i_rst_n;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_byte_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Clock: period 8.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Predictor state: running hash, current block, fill level, bit length.
    logic [31:0] hash_acc [8];
    logic [7:0]  blk_bytes [64];
    int unsigned fill_lvl;
    logic [63:0] msg_bits;

    sha256_pkg::t_in_beat  pending_beats [$];
    sha256_pkg::t_out_beat digest_q [$];

    int  mismatch_cnt;
    bit  failed;
    bit  no_idle;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Compress the current block into hash_acc.
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, w15, w2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
        for (int t = 0; t < 64; t++) begin
            if (t >= 16) begin
                w15 = w[(t-15) & 15];
                w2  = w[(t-2) & 15];
                s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
                s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
                w[t & 15] = w[t & 15] + s0 + w[(t-7) & 15] + s1;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::K[t] + w[t & 15];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
    endtask

    // Advance the predictor by one accepted beat; queue digest words on message end.
    task automatic predict_digest(input sha256_pkg::t_in_beat b);
        sha256_pkg::t_out_beat o;
        if (b.byte_present) begin
            blk_bytes[fill_lvl] = b.message_byte;
            fill_lvl++;
            msg_bits += 64'd8;
            if (fill_lvl == 64) begin
                compress_block();
                fill_lvl = 0;
            end
        end
        if (b.message_end) begin
            blk_bytes[fill_lvl] = sha256_pkg::PAD_BYTE;
            fill_lvl++;
            if (fill_lvl > 56) begin
                for (int i = fill_lvl; i < 64; i++) blk_bytes[i] = 8'h00;
                compress_block();
                fill_lvl = 0;
            end
            for (int i = fill_lvl; i < 56; i++) blk_bytes[i] = 8'h00;
            for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = hash_acc[i];
                o.word_number = i[2:0];
                o.last_word   = (i == 7);
                digest_q.push_back(o);
            end
            for (int i = 0; i < 8; i++) hash_acc[i] = sha256_pkg::H_INIT[i];
            fill_lvl = 0;
            msg_bits = '0;
        end
    endtask

    // Queue one message of random bytes; optionally close with a bare end beat.
    task automatic add_message(input int len, input bit bare_end, input bit noise);
        sha256_pkg::t_in_beat b;
        for (int i = 0; i < len; i++) begin
            b.message_byte = 8'($urandom_range(0, 255));
            b.byte_present = 1'b1;
            b.message_end  = (!bare_end && i == len - 1);
            pending_beats.push_back(b);
            // Sprinkle idle beats that the hasher must ignore.
            if (noise && $urandom_range(0, 19) == 0) begin
                b.message_byte = 8'($urandom_range(0, 255));
                b.byte_present = 1'b0;
                b.message_end  = 1'b0;
                pending_beats.push_back(b);
            end
        end
        if (bare_end || len == 0) begin
            b.message_byte = 8'($urandom_range(0, 255));
            b.byte_present = 1'b0;
            b.message_end  = 1'b1;
            pending_beats.push_back(b);
        end
    endtask

    // Driver: present queued beats, idling at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_digest(in_ch.payload);
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_beats.size() != 0 && (no_idle || $urandom_range(0, 99) >= 10)) begin
                    in_ch.payload <= pending_beats.pop_front();
                    in_ch.valid   <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: take digest words, stall at random, compare with the oldest expectation.
    always @(posedge i_clk) begin
        sha256_pkg::t_out_beat want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (digest_q.size() == 0) begin
                    failed = 1'b1;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected digest beat %h", out_ch.payload);
                end else begin
                    want = digest_q.pop_front();
                    if (out_ch.payload !== want) begin
                        failed = 1'b1;
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp word %h num %0d last %b, got %h num %0d last %b",
                                     want.digest_word, want.word_number, want.last_word,
                                     out_ch.payload.digest_word, out_ch.payload.word_number,
                                     out_ch.payload.last_word);
                    end
                end
            end
            out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 10);
        end
    end

    // Stimulus and end of run.
    initial begin
        int n;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        for (int i = 0; i < 8; i++) hash_acc[i] = sha256_pkg::H_INIT[i];
        fill_lvl = 0;
        msg_bits = '0;
        mismatch_cnt = 0;
        failed = 1'b0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, idle beat, single bytes at the extremes,
        // then three bytes closed by a bare end beat and four bytes.
        add_message(0, 1'b1, 1'b0);
        begin
            sha256_pkg::t_in_beat b;
            b = '{message_byte: 8'hff, byte_present: 1'b0, message_end: 1'b0};
            pending_beats.push_back(b);
            b = '{message_byte: 8'h00, byte_present: 1'b1, message_end: 1'b1};
            pending_beats.push_back(b);
            b = '{message_byte: 8'hff, byte_present: 1'b1, message_end: 1'b1};
            pending_beats.push_back(b);
        end
        add_message(3, 1'b1, 1'b0);
        add_message(4, 1'b0, 1'b0);

        // Random messages; long ones cross block and pad boundaries.
        n = 0;
        while (n < 400) begin
            int len;
            case ($urandom_range(0, 5))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(54, 66);
                2: len = $urandom_range(118, 130);
                default: len = $urandom_range(1, 70);
            endcase
            add_message(len, $urandom_range(0, 3) == 0, 1'b1);
            n += len + 1;
        end

        // Let the first half run with random idling, then a stretch without.
        while (pending_beats.size() >= 200) @(posedge i_clk);
        no_idle = 1'b1;
        while (pending_beats.size() >= 80) @(posedge i_clk);
        no_idle = 1'b0;
        while (pending_beats.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!failed && digest_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Timeout watchdog.
    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ sha256_byte_stream_hasher.f @@
sv/sha256_pkg.sv
sv/sha256_if.sv
sv/sha256_round.sv
sv/sha256_byte_stream_hasher.sv
tb/sv/sha256_byte_stream_hasher_tb.sv
